@@ rtl/sosq_pkg.sv @@
// Shared types and codes for the sortable stack or queue.
// No dependencies; imported by the comparator, the top level, the checker and the testbench.
package sosq_pkg;

    // Width of one stored word (signed Q16.16).
    localparam int VALUE_W = 32;
    // Width of the fill count reported with each result.
    localparam int FILL_W = 7;

    typedef logic signed [VALUE_W-1:0] t_value;

    // Operation codes carried by the kind field.
    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_POP   = 2'd1;
    localparam logic [1:0] KIND_SORT  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_DISCIPLINE = 1'b0;
    localparam logic CFG_SORT_ORDER = 1'b1;

    // Discipline register values.
    localparam logic DISC_STACK = 1'b0;

endpackage

@@ rtl/sosq_cmp.sv @@
// Signed order comparator shared by every compare step of the sort.
// Depends on sosq_pkg for the word type.
module sosq_cmp
    import sosq_pkg::*;
(
    input  t_value i_a,
    input  t_value i_b,
    input  logic   i_descending,
    output logic   o_before
);

    // True when word a belongs strictly before word b in the chosen order.
    always_comb begin
        if (i_descending) begin
            o_before = (i_a > i_b);
        end else begin
            o_before = (i_a < i_b);
        end
    end

endmodule

@@ rtl/sortable_stack_or_queue.sv @@
// Bounded buffer of signed Q16.16 words that acts as a stack or a queue and can
// sort its contents in place; one result word follows every accepted command.
// Depends on sosq_pkg and sosq_cmp.
//
// A command is taken when start is high and busy is low. Push and clear return
// their result in the next cycle and leave busy low, so a command may follow every
// cycle. A stack pop, a queue pop and a sort hold busy high while they run; the
// queue pop and the sort run longer with more stored entries, all because of the
// single read port of the entry memory that each step of the queue shift and of
// the insertion sort goes through. The result is on the outputs for exactly one
// cycle with o_strobe high and must be taken then: there is no way to hold it off.
// The entry memory needs no clearing after reset; only entries below the fill
// count are ever put to use.
module sortable_stack_or_queue
    import sosq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_kind,
    input  t_value            i_value,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic              i_cfg_data,
    output logic              o_strobe,
    output t_value            o_popped_value,
    output logic [1:0]        o_status,
    output logic [FILL_W-1:0] o_fill_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_OUT,
        ST_Q_HEAD,
        ST_Q_SHIFT,
        ST_SORT_RDKEY,
        ST_SORT_KEY,
        ST_SORT_CMP,
        ST_SORT_PUT
    } t_state;

    // Registers.
    t_state            r_state,   n_state;
    logic [CW-1:0]     r_count,   n_count;
    logic              r_disc;
    logic              r_order;
    logic [AW-1:0]     r_i,       n_i;
    logic [AW-1:0]     r_j,       n_j;
    t_value            r_key,     n_key;
    t_value            r_pop,     n_pop;
    logic              r_strobe,  n_strobe;
    t_value            r_popped,  n_popped;
    logic [1:0]        r_status,  n_status;
    logic [FILL_W-1:0] r_fill,    n_fill;
    t_value            r_rdata;

    // Memory port controls.
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    t_value            mem_wd;
    logic [AW-1:0]     rd_addr;

    logic [CW-1:0]     cnt_m1;
    logic              more_keys;
    logic              key_first;

    t_value            mem [DEPTH];

    assign cnt_m1    = r_count - 1'b1;
    // Another insertion key remains when i + 1 is below the count.
    assign more_keys = ((CW'(r_i) + CW'(1)) < r_count);

    // Shared compare unit: key against the word just read.
    sosq_cmp u_cmp (
        .i_a          (r_key),
        .i_b          (r_rdata),
        .i_descending (r_order),
        .o_before     (key_first)
    );

    // Entry memory: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[rd_addr];
    end

    // Sequencer next-state logic.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_i      = r_i;
        n_j      = r_j;
        n_key    = r_key;
        n_pop    = r_pop;
        n_strobe = 1'b0;
        n_popped = '0;
        n_status = STATUS_OK;
        mem_we   = 1'b0;
        mem_wa   = r_j;
        mem_wd   = r_rdata;
        rd_addr  = r_i;

        case (r_state)
            ST_IDLE: begin
                // Prefetch the word a pop would remove.
                rd_addr = (r_disc == DISC_STACK) ? cnt_m1[AW-1:0] : '0;
                if (start) begin
                    case (i_kind)
                        KIND_PUSH: begin
                            n_strobe = 1'b1;
                            if (r_count < CW'(DEPTH)) begin
                                mem_we  = 1'b1;
                                mem_wa  = r_count[AW-1:0];
                                mem_wd  = i_value;
                                n_count = r_count + 1'b1;
                            end else begin
                                n_status = STATUS_FULL;
                            end
                        end
                        KIND_POP: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_status = STATUS_EMPTY;
                            end else if (r_disc == DISC_STACK) begin
                                n_state = ST_POP_OUT;
                            end else begin
                                n_state = ST_Q_HEAD;
                            end
                        end
                        KIND_SORT: begin
                            if (r_count > CW'(1)) begin
                                n_i     = AW'(1);
                                n_state = ST_SORT_RDKEY;
                            end else begin
                                n_strobe = 1'b1;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_count  = '0;
                        end
                    endcase
                end
            end

            ST_POP_OUT: begin
                n_strobe = 1'b1;
                n_popped = r_rdata;
                n_count  = cnt_m1;
                n_state  = ST_IDLE;
            end

            ST_Q_HEAD: begin
                // Head word is in hand; start moving the rest down by one place, toward the head.
                n_pop   = r_rdata;
                rd_addr = AW'(1);
                n_i     = AW'(1);
                if (r_count == CW'(1)) begin
                    n_strobe = 1'b1;
                    n_popped = r_rdata;
                    n_count  = cnt_m1;
                    n_state  = ST_IDLE;
                end else begin
                    n_state = ST_Q_SHIFT;
                end
            end

            ST_Q_SHIFT: begin
                // Word i has arrived: write it one place lower.
                mem_we  = 1'b1;
                mem_wa  = r_i - 1'b1;
                mem_wd  = r_rdata;
                rd_addr = r_i + 1'b1;
                if (more_keys) begin
                    n_i = r_i + 1'b1;
                end else begin
                    n_strobe = 1'b1;
                    n_popped = r_pop;
                    n_count  = cnt_m1;
                    n_state  = ST_IDLE;
                end
            end

            ST_SORT_RDKEY: begin
                rd_addr = r_i;
                n_state = ST_SORT_KEY;
            end

            ST_SORT_KEY: begin
                n_key   = r_rdata;
                n_j     = r_i;
                rd_addr = r_i - 1'b1;
                n_state = ST_SORT_CMP;
            end

            ST_SORT_CMP: begin
                // Compare the key with word j-1, now in the read register.
                mem_we = 1'b1;
                mem_wa = r_j;
                if (key_first) begin
                    mem_wd  = r_rdata;
                    n_j     = r_j - 1'b1;
                    rd_addr = r_j - AW'(2);
                    if (r_j == AW'(1)) begin
                        n_state = ST_SORT_PUT;
                    end
                end else begin
                    mem_wd = r_key;
                    if (more_keys) begin
                        n_i     = r_i + 1'b1;
                        n_state = ST_SORT_RDKEY;
                    end else begin
                        n_strobe = 1'b1;
                        n_state  = ST_IDLE;
                    end
                end
            end

            ST_SORT_PUT: begin
                // The key belongs at the very front.
                mem_we = 1'b1;
                mem_wa = r_j;
                mem_wd = r_key;
                if (more_keys) begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_SORT_RDKEY;
                end else begin
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_fill = FILL_W'(n_count);
    end

    // State, configuration and registered result word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_disc   <= 1'b0;
            r_order  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DISCIPLINE: r_disc  <= i_cfg_data;
                    CFG_SORT_ORDER: r_order <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        r_i      <= n_i;
        r_j      <= n_j;
        r_key    <= n_key;
        r_pop    <= n_pop;
        r_popped <= n_popped;
        r_status <= n_status;
        r_fill   <= n_fill;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_strobe       = r_strobe;
    assign o_popped_value = r_popped;
    assign o_status       = r_status;
    assign o_fill_count   = r_fill;

endmodule

@@ dv/sosq_checker.sv @@
// Result checker for the sortable stack or queue: keeps its own copy of the buffer,
// predicts one result word per accepted command and compares it with the block's.
// Depends on sosq_pkg for the value type, the operation and the status codes.
`timescale 1ns / 1ps

module sosq_checker
    import sosq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [1:0]        i_kind,
    input  t_value            i_value,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic              i_cfg_data,
    input  logic              i_strobe,
    input  t_value            i_popped_value,
    input  logic [1:0]        i_status,
    input  logic [FILL_W-1:0] i_fill_count,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_results_seen,
    output int                o_full_hits,
    output int                o_empty_hits,
    output int                o_sorts_seen
);

    // A set sort order bit means descending.
    localparam logic ORDER_DESC = 1'b1;

    typedef struct packed {
        t_value            popped;
        logic [1:0]        status;
        logic [FILL_W-1:0] fill;
    } t_buf_result;

    // Shadow copy of the buffer and its registers.
    t_value      shadow_mem [DEPTH];
    int          shadow_count;
    logic        shadow_disc;
    logic        shadow_order;

    // Result words still to come from the block, oldest first.
    t_buf_result result_backlog [$];

    int fails;
    int results_seen;
    int full_hits;
    int empty_hits;
    int sorts_seen;

    // True when a belongs in front of b under the current sort order.
    function automatic logic ranks_ahead(t_value a, t_value b);
        if (shadow_order == ORDER_DESC)
            return a > b;
        return a < b;
    endfunction

    // Insertion sort over the stored words only.
    function automatic void sort_shadow();
        int     i;
        int     j;
        t_value key;
        for (i = 1; i < shadow_count; i++) begin
            key = shadow_mem[i];
            j = i;
            while (j > 0 && ranks_ahead(key, shadow_mem[j-1])) begin
                shadow_mem[j] = shadow_mem[j-1];
                j--;
            end
            shadow_mem[j] = key;
        end
    endfunction

    // Applies one command to the shadow buffer and returns the word it should produce.
    function automatic t_buf_result apply_command(logic [1:0] kind, t_value value);
        t_buf_result res;
        int          i;
        res.popped = '0;
        res.status = STATUS_OK;
        case (kind)
            KIND_PUSH: begin
                if (shadow_count < DEPTH) begin
                    shadow_mem[shadow_count] = value;
                    shadow_count++;
                end else begin
                    res.status = STATUS_FULL;
                end
            end
            KIND_POP: begin
                if (shadow_count == 0) begin
                    res.status = STATUS_EMPTY;
                end else if (shadow_disc == DISC_STACK) begin
                    shadow_count--;
                    res.popped = shadow_mem[shadow_count];
                end else begin
                    // Queue pop: take the head and close the gap.
                    res.popped = shadow_mem[0];
                    for (i = 1; i < shadow_count; i++)
                        shadow_mem[i-1] = shadow_mem[i];
                    shadow_count--;
                end
            end
            KIND_SORT: begin
                sort_shadow();
            end
            KIND_CLEAR: begin
                shadow_count = 0;
            end
            default: ;
        endcase
        res.fill = FILL_W'(shadow_count);
        return res;
    endfunction

    // Compares one result word from the block with the oldest prediction.
    task automatic check_word();
        t_buf_result want;
        if (result_backlog.size() == 0) begin
            $error("result word with no command awaiting it: popped_value %0d status %0d",
                   i_popped_value, i_status);
            fails++;
            return;
        end
        want = result_backlog.pop_front();
        if (want.status == STATUS_FULL)
            full_hits++;
        if (want.status == STATUS_EMPTY)
            empty_hits++;
        if (i_popped_value !== want.popped) begin
            $error("popped_value: expected %0d, got %0d", want.popped, i_popped_value);
            fails++;
        end
        if (i_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, i_status);
            fails++;
        end
        if (i_fill_count !== want.fill) begin
            $error("fill_count: expected %0d, got %0d", want.fill, i_fill_count);
            fails++;
        end
    endtask

    // Watch both channels and the register port at every rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_count = 0;
            shadow_disc  = DISC_STACK;
            shadow_order = 1'b0;
            result_backlog.delete();
        end else begin
            // Results are checked before new commands are predicted.
            if (i_strobe) begin
                results_seen++;
                check_word();
            end
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_DISCIPLINE)
                    shadow_disc = i_cfg_data;
                else
                    shadow_order = i_cfg_data;
            end
            if (i_start && !i_busy) begin
                if (i_kind == KIND_SORT && shadow_count > 1)
                    sorts_seen++;
                result_backlog.push_back(apply_command(i_kind, i_value));
            end
        end
        o_pending      <= result_backlog.size();
        o_fail_count   <= fails;
        o_results_seen <= results_seen;
        o_full_hits    <= full_hits;
        o_empty_hits   <= empty_hits;
        o_sorts_seen   <= sorts_seen;
    end

    initial begin
        fails        = 0;
        results_seen = 0;
        full_hits    = 0;
        empty_hits   = 0;
        sorts_seen   = 0;
        shadow_count = 0;
        shadow_disc  = DISC_STACK;
        shadow_order = 1'b0;
        foreach (shadow_mem[k])
            shadow_mem[k] = '0;
    end

endmodule

@@ dv/sortable_stack_or_queue_tb.sv @@
// Top of the testbench for the sortable stack or queue: clock, reset, command and
// register stimulus, an idle watchdog and the verdict. Depends on sosq_pkg, the
// block itself and sosq_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module sortable_stack_or_queue_tb;
    import sosq_pkg::*;

    localparam int DEPTH       = 64;
    localparam int ITEM_TARGET = 1100;
    // The slowest command is a sort of a full buffer.
    localparam int IDLE_LIMIT  = 20000;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        i_kind;
    t_value            i_value;
    logic              i_cfg_we;
    logic              i_cfg_index;
    logic              i_cfg_data;
    logic              o_strobe;
    t_value            o_popped_value;
    logic [1:0]        o_status;
    logic [FILL_W-1:0] o_fill_count;

    int fail_count;
    int pending;
    int results_seen;
    int full_hits;
    int empty_hits;
    int sorts_seen;

    int items_sent;
    int phase_no;
    int burst_left;
    int idle_cycles;

    sortable_stack_or_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_value        (i_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_fill_count   (o_fill_count)
    );

    sosq_checker #(
        .DEPTH(DEPTH)
    ) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_kind         (i_kind),
        .i_value        (i_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_strobe       (o_strobe),
        .i_popped_value (o_popped_value),
        .i_status       (o_status),
        .i_fill_count   (o_fill_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen),
        .o_full_hits    (full_hits),
        .o_empty_hits   (empty_hits),
        .o_sorts_seen   (sorts_seen)
    );

    // Clock with a 4 ns period.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: ends the run if neither a command nor a result word moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Sends one command word, with the random bursts and gaps of the sender.
    task automatic send_command(logic [1:0] kind, t_value value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            // About a third of the bursts follow on without any gap.
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        start   <= 1'b1;
        i_kind  <= kind;
        i_value <= value;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
    endtask

    // Drops start and waits until every result word is in and the block is idle.
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
    endtask

    // Writes one register; only called while the block is idle.
    task automatic write_reg(logic index, logic data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mix of extremes, Q16.16 integers, near-equal small words and raw random bits.
    function automatic t_value pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return t_value'(int'($urandom_range(0, 4)) - 2);
            3: return t_value'((int'($urandom_range(0, 15)) - 8) * 65536);
            default: return t_value'($urandom);
        endcase
    endfunction

    // Operation mix for the three random phase styles.
    function automatic logic [1:0] pick_kind(int style);
        int r;
        r = $urandom_range(0, 99);
        case (style)
            0: begin
                if (r < 78) return KIND_PUSH;
                if (r < 92) return KIND_POP;
                if (r < 97) return KIND_SORT;
            end
            1: begin
                if (r < 30) return KIND_PUSH;
                if (r < 88) return KIND_POP;
                if (r < 96) return KIND_SORT;
            end
            default: begin
                if (r < 48) return KIND_PUSH;
                if (r < 88) return KIND_POP;
                if (r < 97) return KIND_SORT;
            end
        endcase
        return KIND_CLEAR;
    endfunction

    // Stimulus: reset, a directed opening, then random phases under changing settings.
    initial begin
        int   len;
        int   n;
        logic disc;
        logic order;

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_kind      = KIND_PUSH;
        i_value     = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_DISCIPLINE;
        i_cfg_data  = 1'b0;
        items_sent  = 0;
        phase_no    = 0;
        burst_left  = 0;
        idle_cycles = 0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: stack, ascending.
        write_reg(CFG_DISCIPLINE, DISC_STACK);
        write_reg(CFG_SORT_ORDER, 1'b0);
        send_command(KIND_POP, '0);
        send_command(KIND_SORT, 32'sh5A5A_A5A5);
        send_command(KIND_CLEAR, '1);
        send_command(KIND_PUSH, 32'sh7FFF_FFFF);
        send_command(KIND_PUSH, 32'sh8000_0000);
        send_command(KIND_PUSH, 32'sh0000_0000);
        send_command(KIND_PUSH, 32'shFFFF_FFFF);
        send_command(KIND_PUSH, 32'sh0001_0000);
        send_command(KIND_PUSH, 32'sh0000_0001);
        send_command(KIND_SORT, '0);
        send_command(KIND_POP, '0);
        send_command(KIND_POP, '0);
        settle();

        // Queue, descending, on the same contents.
        write_reg(CFG_DISCIPLINE, ~DISC_STACK);
        write_reg(CFG_SORT_ORDER, 1'b1);
        send_command(KIND_SORT, '0);
        send_command(KIND_POP, '0);
        send_command(KIND_PUSH, 32'sh8000_0000);
        send_command(KIND_PUSH, 32'sh7FFF_FFFF);
        send_command(KIND_PUSH, 32'sh8000_0000);
        send_command(KIND_SORT, '0);
        send_command(KIND_POP, '0);
        send_command(KIND_CLEAR, '0);
        send_command(KIND_POP, '0);
        settle();

        // Random phases; the first four walk every register setting.
        while (items_sent < ITEM_TARGET) begin
            if (phase_no < 4) begin
                disc  = phase_no[0];
                order = phase_no[1];
            end else begin
                disc  = $urandom_range(0, 1);
                order = $urandom_range(0, 1);
            end
            write_reg(CFG_DISCIPLINE, disc);
            write_reg(CFG_SORT_ORDER, order);

            if (phase_no % 4 == 3) begin
                // Fill past full, sort, then drain past empty.
                for (n = 0; n < DEPTH + 2; n++)
                    send_command(KIND_PUSH, pick_value());
                send_command(KIND_SORT, t_value'($urandom));
                for (n = 0; n < DEPTH + 2; n++)
                    send_command(KIND_POP, t_value'($urandom));
            end else begin
                len = $urandom_range(40, 120);
                for (n = 0; n < len; n++)
                    send_command(pick_kind(phase_no % 4), pick_value());
            end
            settle();
            phase_no++;
        end

        repeat (8) @(posedge i_clk);
        $display("Ran %0d commands in %0d random phases; %0d result words checked.",
                 items_sent, phase_no, results_seen);
        $display("Refused pushes: %0d, empty pops: %0d, sorts of two or more words: %0d.",
                 full_hits, empty_hits, sorts_seen);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/sosq_pkg.sv
rtl/sosq_cmp.sv
rtl/sortable_stack_or_queue.sv
dv/sosq_checker.sv
dv/sortable_stack_or_queue_tb.sv
